[hw/rtl/lps_pkg.sv]
package lps_pkg;

  // Command codes carried in an input item
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_OFFER = 1'b1;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_LED_COUNT   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ZERO_HIGH   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ONE_HIGH    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BIT_PERIOD  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LATCH_TICKS = 3'd4;
  localparam int CfgDataW = 16;

  // Configuration reset values
  localparam logic [10:0] LED_COUNT_RST   = 11'd1;
  localparam logic [7:0]  ZERO_HIGH_RST   = 8'd7;
  localparam logic [7:0]  ONE_HIGH_RST    = 8'd14;
  localparam logic [7:0]  BIT_PERIOD_RST  = 8'd40;
  localparam logic [15:0] LATCH_TICKS_RST = 16'd1600;

  // Serializer phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_BITS  = 2'd1;
  localparam logic [1:0] PH_LATCH = 2'd2;

  localparam logic [4:0] PIXEL_BITS = 5'd24;

  typedef struct packed {
    logic       command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic pixel_taken;
    logic holding_free;
    logic sending;
    logic frame_done;
  } out_item_t;

  typedef struct packed {
    logic [10:0] led_count;
    logic [7:0]  zero_high_ticks;
    logic [7:0]  one_high_ticks;
    logic [7:0]  bit_period_ticks;
    logic [15:0] latch_ticks;
  } cfg_t;

endpackage

[hw/rtl/lps_cfg.sv]
module lps_cfg
  import lps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.led_count        <= LED_COUNT_RST;
      cfg.zero_high_ticks  <= ZERO_HIGH_RST;
      cfg.one_high_ticks   <= ONE_HIGH_RST;
      cfg.bit_period_ticks <= BIT_PERIOD_RST;
      cfg.latch_ticks      <= LATCH_TICKS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LED_COUNT:   cfg.led_count        <= cfg_data[10:0];
        REG_ZERO_HIGH:   cfg.zero_high_ticks  <= cfg_data[7:0];
        REG_ONE_HIGH:    cfg.one_high_ticks   <= cfg_data[7:0];
        REG_BIT_PERIOD:  cfg.bit_period_ticks <= cfg_data[7:0];
        REG_LATCH_TICKS: cfg.latch_ticks      <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

[hw/rtl/lps_core.sv]
module lps_core
  import lps_pkg::*;
#(
  parameter int MAX_LEDS = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  localparam int CntW = $clog2(MAX_LEDS + 1);
  localparam logic [16:0] MaxLeds = 17'(MAX_LEDS);

  logic [23:0]     shift_bits, shift_bits_next;
  logic [4:0]      bits_left, bits_left_next;
  logic [7:0]      tick_in_bit, tick_in_bit_next;
  logic [CntW-1:0] pixels_sent, pixels_sent_next;
  logic [15:0]     latch_count, latch_count_next;
  logic [23:0]     held_pixel, held_pixel_next;
  logic            held_valid, held_valid_next;
  logic [1:0]      phase, phase_next;

  logic [16:0]     led_ext, flen_ext;
  logic [CntW-1:0] flen;
  logic [7:0]      high_ticks;
  logic [8:0]      tick_inc;
  logic [CntW:0]   pix_inc;
  logic [16:0]     latch_inc;

  // Frame length clamped to 1..MAX_LEDS
  always_comb begin
    led_ext = {6'd0, cfg.led_count};
    if (led_ext == 17'd0) begin
      flen_ext = 17'd1;
    end else if (led_ext > MaxLeds) begin
      flen_ext = MaxLeds;
    end else begin
      flen_ext = led_ext;
    end
    flen = flen_ext[CntW-1:0];
  end

  always_comb begin
    shift_bits_next  = shift_bits;
    bits_left_next   = bits_left;
    tick_in_bit_next = tick_in_bit;
    pixels_sent_next = pixels_sent;
    latch_count_next = latch_count;
    held_pixel_next  = held_pixel;
    held_valid_next  = held_valid;
    phase_next       = phase;
    high_ticks       = '0;
    tick_inc         = '0;
    pix_inc          = '0;
    latch_inc        = '0;
    result           = '0;

    if (item.command == CMD_OFFER) begin
      if (!held_valid) begin
        held_pixel_next    = {item.green, item.red, item.blue};
        held_valid_next    = 1'b1;
        result.pixel_taken = 1'b1;
      end
      result.sending = (phase != PH_IDLE);
    end else begin
      if (phase != PH_BITS && phase != PH_LATCH) begin
        if (held_valid) begin
          shift_bits_next  = held_pixel;
          held_valid_next  = 1'b0;
          bits_left_next   = PIXEL_BITS;
          tick_in_bit_next = '0;
          pixels_sent_next = '0;
          phase_next       = PH_BITS;
        end else begin
          phase_next = PH_IDLE;
        end
      end else if (phase == PH_BITS && bits_left == '0 && held_valid) begin
        shift_bits_next  = held_pixel;
        held_valid_next  = 1'b0;
        bits_left_next   = PIXEL_BITS;
        tick_in_bit_next = '0;
      end

      if (phase_next == PH_BITS) begin
        result.sending = 1'b1;
        // underrun: with no bits left the line stays low until a pixel arrives
        if (bits_left_next != '0) begin
          high_ticks = shift_bits_next[23] ? cfg.one_high_ticks : cfg.zero_high_ticks;
          result.line_level = (tick_in_bit_next < high_ticks);
          tick_inc = {1'b0, tick_in_bit_next} + 9'd1;
          if (tick_inc >= {1'b0, cfg.bit_period_ticks}) begin
            tick_in_bit_next = '0;
            shift_bits_next  = {shift_bits_next[22:0], 1'b0};
            bits_left_next   = bits_left_next - 5'd1;
            if (bits_left_next == '0) begin
              pix_inc          = {1'b0, pixels_sent_next} + {{CntW{1'b0}}, 1'b1};
              pixels_sent_next = pix_inc[CntW-1:0];
              if (pix_inc >= {1'b0, flen}) begin
                phase_next       = PH_LATCH;
                latch_count_next = '0;
              end
            end
          end else begin
            tick_in_bit_next = tick_inc[7:0];
          end
        end
      end else if (phase_next == PH_LATCH) begin
        result.sending = 1'b1;
        latch_inc = {1'b0, latch_count_next} + 17'd1;
        if (latch_inc >= {1'b0, cfg.latch_ticks}) begin
          latch_count_next  = '0;
          pixels_sent_next  = '0;
          phase_next        = PH_IDLE;
          result.frame_done = 1'b1;
        end else begin
          latch_count_next = latch_inc[15:0];
        end
      end
    end

    result.holding_free = !held_valid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits  <= '0;
      bits_left   <= '0;
      tick_in_bit <= '0;
      pixels_sent <= '0;
      latch_count <= '0;
      held_valid  <= 1'b0;
      phase       <= PH_IDLE;
    end else if (step) begin
      shift_bits  <= shift_bits_next;
      bits_left   <= bits_left_next;
      tick_in_bit <= tick_in_bit_next;
      pixels_sent <= pixels_sent_next;
      latch_count <= latch_count_next;
      held_valid  <= held_valid_next;
      phase       <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held_pixel <= held_pixel_next;
    end
  end

endmodule

[hw/rtl/rgb_led_pulse_width_serializer.sv]
// Single-wire RGB LED strip serializer. Each input transfer is either a time
// tick or a pixel offer, and each one yields exactly one result transfer that
// reports the line level for that tick, whether the offered pixel was taken,
// whether the one-pixel holding register is free, whether a frame is in
// progress, and whether the latch period just ended. Pixels go out green, red,
// blue, most significant bit first, with bit timing set by the tick
// registers. The block takes one transfer per clock; each result passes
// through the input register, then the result register, and a stalled
// result register holds back the input side. Configuration may be written
// only while no transfer is in flight.
module rgb_led_pulse_width_serializer
  import lps_pkg::*;
#(
  parameter int MAX_LEDS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_item,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_valid;
  logic      out_free;
  logic      advance;
  out_item_t result;

  assign out_free = !out_valid || !out_stall;
  assign advance  = item_valid && out_free;
  assign in_stall = item_valid && !out_free;

  lps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lps_core #(
    .MAX_LEDS (MAX_LEDS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item_q),
    .cfg    (cfg),
    .result (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_q <= in_item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

endmodule
